// ----- rtl/core/flac_pkg.sv -----
// ----------------------------------------------------------------------------
// flac_pkg
// Shared types and constants for the fully associative LRU tag cache.
// ----------------------------------------------------------------------------
package flac_pkg;

  localparam int WAYS   = 8;
  localparam int WAYS_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;
  localparam int SLOT_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef logic [WAYS_W-1:0] way_t;
  typedef logic [ADDR_W-1:0] tag_t;

  // Recency update request from the sequencer to the LRU order
  typedef struct packed {
    logic en;
    way_t way;
  } touch_t;

endpackage

// ----- rtl/core/flac_lru.sv -----
// ----------------------------------------------------------------------------
// flac_lru
// Recency order of the cache slots, front = most recently used.
// ----------------------------------------------------------------------------
module flac_lru (
  input  logic              clk,
  input  logic              rst_n,
  input  flac_pkg::touch_t  touch,
  output flac_pkg::way_t    victim
);

  flac_pkg::way_t order_r   [flac_pkg::WAYS];
  flac_pkg::way_t order_nxt [flac_pkg::WAYS];
  flac_pkg::way_t pos;

  assign victim = order_r[flac_pkg::WAYS-1];

  // Find the touched slot (back entry if absent), shift the entries in
  // front of it back by one and place the slot at the front.
  always_comb begin
    pos = flac_pkg::way_t'(flac_pkg::WAYS-1);
    for (int k = flac_pkg::WAYS-1; k >= 0; k--) begin
      if (order_r[k] == touch.way) begin
        pos = flac_pkg::way_t'(k);
      end
    end
    order_nxt[0] = touch.way;
    for (int p = 1; p < flac_pkg::WAYS; p++) begin
      if (flac_pkg::way_t'(p) <= pos) begin
        order_nxt[p] = order_r[p-1];
      end else begin
        order_nxt[p] = order_r[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < flac_pkg::WAYS; k++) begin
        order_r[k] <= flac_pkg::way_t'(flac_pkg::WAYS-1-k);
      end
    end else if (touch.en) begin
      for (int k = 0; k < flac_pkg::WAYS; k++) begin
        order_r[k] <= order_nxt[k];
      end
    end
  end

endmodule

// ----- rtl/core/fully_assoc_lru_tag_cache_core.sv -----
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_cache_core
// Eight-way fully associative tag cache with LRU replacement and counters.
// ----------------------------------------------------------------------------
// Each input transaction carries one address. A single tag comparator walks
// the slots one per cycle, lowest slot first, and stops at the first valid
// slot whose tag equals the address. A hit ends the walk at its slot and a
// miss walks every slot; either way the sequencer then moves through the
// update state and the done state, from which the result is loaded into the
// result register once that is free. Only one transaction is in flight:
// in_stall stays high from acceptance until its result is
// loaded into the output register, which may still be waiting to be taken
// when the next transaction is accepted. On a miss the address replaces the
// least recently used slot, which becomes valid. Either way the slot moves
// to the front of the recency order. Hit and access counts saturate at
// all ones. After reset no slot is valid, so address zero misses.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_cache_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [2:0]  out_slot,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_access_count
);

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  flac_pkg::tag_t         addr_r;
  flac_pkg::way_t         idx_r, idx_nxt;
  logic                   hit_r, hit_nxt;
  flac_pkg::way_t         way_r, way_nxt;
  flac_pkg::tag_t         tag_r [flac_pkg::WAYS];
  logic [flac_pkg::WAYS-1:0] valid_r;
  logic [flac_pkg::CNT_W-1:0] hits_r, acc_r;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [2:0]             out_slot_r;
  logic [31:0]            out_hit_count_r, out_access_count_r;

  logic                   in_take;
  logic                   out_load;
  logic                   match;
  flac_pkg::way_t         victim;
  flac_pkg::touch_t       touch;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // The shared comparator: one slot per cycle
  assign match = valid_r[idx_r] && (tag_r[idx_r] == addr_r);

  assign touch.en  = (state_r == S_UPDATE);
  assign touch.way = way_r;

  flac_lru u_lru (
    .clk    (clk),
    .rst_n  (rst_n),
    .touch  (touch),
    .victim (victim)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    way_nxt   = way_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (match) begin
          // Hit: stop the walk at the first matching slot
          hit_nxt   = 1'b1;
          way_nxt   = idx_r;
          state_nxt = S_UPDATE;
        end else if (idx_r == flac_pkg::way_t'(flac_pkg::WAYS-1)) begin
          // Miss: take the least recently used slot
          hit_nxt   = 1'b0;
          way_nxt   = victim;
          state_nxt = S_UPDATE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_UPDATE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      hits_r  <= '0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_UPDATE) begin
        // Count the access, and the hit if any; hold at the maximum
        if (acc_r != flac_pkg::COUNT_MAX) begin
          acc_r <= acc_r + 1'b1;
        end
        if (hit_r && (hits_r != flac_pkg::COUNT_MAX)) begin
          hits_r <= hits_r + 1'b1;
        end
        if (!hit_r) begin
          valid_r[way_r] <= 1'b1;
        end
      end
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    way_r <= way_nxt;
    if (in_take) begin
      addr_r <= flac_pkg::tag_t'(in_address);
    end
    if ((state_r == S_UPDATE) && !hit_r) begin
      tag_r[way_r] <= addr_r;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r          <= hit_r;
      out_slot_r         <= 3'(way_r);
      out_hit_count_r    <= 32'(hits_r);
      out_access_count_r <= 32'(acc_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_slot         = out_slot_r;
  assign out_hit_count    = out_hit_count_r;
  assign out_access_count = out_access_count_r;

`ifndef SYNTHESIS
  // A hit can only come from a slot that already holds a valid tag
  a_hit_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) && match |=> valid_r[way_r])
    else $error("hit reported on an invalid slot");

  // Hits never outrun accesses
  a_hits_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hit_count_r <= out_access_count_r))
    else $error("hit count exceeds access count");

  // A miss leaves the filled slot valid
  a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) && !hit_r |=> valid_r[$past(way_r)])
    else $error("miss did not mark its slot valid");
`endif

endmodule
